### sv/vzre_pkg.sv
// ----------------------------------------------------------------------------
// vzre_pkg
// shared types and constants of the voxel zero run encoder
// ----------------------------------------------------------------------------
package vzre_pkg;

    localparam int CHUNK_VOXELS = 4096;
    localparam int POS_W        = $clog2(CHUNK_VOXELS);
    localparam int RUN_W        = POS_W + 1;

    // records one voxel can release, and the record queue behind them
    localparam int MAX_RECS     = 3;
    localparam int REC_CNT_W    = $clog2(MAX_RECS + 1);
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

    localparam logic [1:0] THRESHOLD_CAP = 2'd3;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MARKER_VALUE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RUN      = 1'd1;

    typedef enum logic [1:0] {
        KIND_LITERAL = 2'd0,
        KIND_RUN     = 2'd1,
        KIND_EMPTY   = 2'd2
    } rec_kind_t;

    typedef struct packed {
        logic [1:0]       record_kind;
        logic [7:0]       out_value;
        logic [7:0]       out_color;
        logic [RUN_W-1:0] run_length;
        logic             chunk_end;
        logic             last;
    } rec_t;

endpackage

### sv/voxel_zero_run_encoder_top.sv
// ----------------------------------------------------------------------------
// voxel_zero_run_encoder_top
// zero run length encoder for voxel chunks
// ----------------------------------------------------------------------------
// voxels enter on the s_ stream in chunk order, one word per voxel; records
// leave on the m_ stream. a zero voxel is held back as part of a run and
// gives no record until the run ends at a non-zero voxel or at the chunk
// boundary. one voxel releases zero to three records; m_tuser marks the last
// record of a voxel and m_tlast the last record of a chunk.
// the encode logic sits between the position/run counters and a four-word
// record queue; records are registered there and leave from its head on m_tdata.
// s_tready depends on queue fill only: a voxel is taken whenever the queue
// has room for three records, so voxels giving one record flow at one per
// cycle while m_tready stays high; voxels giving more records are slowed by the
// single output port. a stalled receiver fills the queue and then holds s_tready low.
// reset empties the queue, clears the chunk position and the held run, and
// sets marker_value to 255 and min_run to 3. the user writes the registers
// through cfg_we/cfg_index/cfg_wdata only while the block is idle; not enforced.
// ----------------------------------------------------------------------------
module voxel_zero_run_encoder_top (
    input  logic                              clk,
    input  logic                              rst_n,
    // voxel_value [7:0], voxel_color [15:8]
    input  logic [15:0]                       s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // record_kind [1:0], out_value [9:2], out_color [17:10], run_length [30:18]
    output logic [31:0]                       m_tdata,
    output logic                              m_tuser,   // last record of the voxel
    output logic                              m_tlast,   // chunk_end
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_we,
    input  logic [vzre_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [7:0]                        cfg_wdata
);
    import vzre_pkg::*;

    logic [7:0]           marker_reg;
    logic [3:0]           min_run_reg;
    logic [POS_W-1:0]     pos_reg;
    logic [POS_W-1:0]     pos_next;
    logic [RUN_W-1:0]     zcount_reg;
    logic [RUN_W-1:0]     zcount_next;

    logic                 accept;
    logic [7:0]           voxel_value;
    logic [7:0]           voxel_color;
    logic                 at_end;
    logic                 is_zero;
    logic [RUN_W-1:0]     cnt_inc;
    logic [RUN_W-1:0]     flush_n;
    logic [1:0]           thresh;
    logic                 empty_chunk;
    logic                 do_flush;
    logic                 run_rec;
    logic [1:0]           zero_lits;
    rec_t                 recs [MAX_RECS];
    logic [REC_CNT_W-1:0] rec_cnt;
    logic [REC_CNT_W-1:0] push_cnt;
    logic                 room;
    rec_t                 out_rec;

    assign voxel_value = s_tdata[7:0];
    assign voxel_color = s_tdata[15:8];
    assign s_tready    = room;
    assign accept      = s_tvalid && s_tready;
    assign push_cnt    = accept ? rec_cnt : '0;

    assign at_end  = (pos_reg == POS_W'(CHUNK_VOXELS - 1));
    assign is_zero = (voxel_value == 8'd0);
    assign cnt_inc = zcount_reg + RUN_W'(1);

    always_comb
    begin
        if (min_run_reg == 4'd0)
            thresh = 2'd1;
        else if (min_run_reg > {2'b00, THRESHOLD_CAP})
            thresh = THRESHOLD_CAP;
        else
            thresh = min_run_reg[1:0];
    end

    always_comb
    begin
        rec_t blank;
        logic [REC_CNT_W-1:0] k;

        blank       = '0;
        flush_n     = is_zero ? cnt_inc : zcount_reg;
        empty_chunk = is_zero && at_end && (cnt_inc >= RUN_W'(CHUNK_VOXELS));
        do_flush    = !empty_chunk && (!is_zero || at_end) && (flush_n != '0);
        run_rec     = do_flush && (flush_n >= RUN_W'(thresh));
        // below the threshold the run is at most two voxels long
        zero_lits   = (do_flush && !run_rec) ? flush_n[1:0] : 2'd0;

        for (int i = 0; i < MAX_RECS; i++)
        begin
            recs[i] = blank;
        end
        k = '0;

        if (empty_chunk)
        begin
            recs[0].record_kind = KIND_EMPTY;
            k = REC_CNT_W'(1);
        end
        if (run_rec)
        begin
            recs[0].record_kind = KIND_RUN;
            recs[0].out_value   = marker_reg;
            recs[0].out_color   = marker_reg;
            recs[0].run_length  = flush_n;
            k = REC_CNT_W'(1);
        end
        // zero literals are all-zero records, already in place
        k = k + REC_CNT_W'(zero_lits);
        if (!is_zero)
        begin
            recs[k[1:0]].record_kind = KIND_LITERAL;
            recs[k[1:0]].out_value   = voxel_value;
            recs[k[1:0]].out_color   = voxel_color;
            k = k + REC_CNT_W'(1);
        end
        if (k != '0)
        begin
            recs[k[1:0] - 2'd1].last      = 1'b1;
            recs[k[1:0] - 2'd1].chunk_end = at_end;
        end
        rec_cnt = k;
    end

    always_comb
    begin
        pos_next    = at_end ? '0 : pos_reg + POS_W'(1);
        zcount_next = (at_end || !is_zero) ? '0 : cnt_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            zcount_reg <= '0;
        end
        else if (accept)
        begin
            pos_reg    <= pos_next;
            zcount_reg <= zcount_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_reg  <= 8'd255;
            min_run_reg <= 4'd3;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MARKER_VALUE: marker_reg  <= cfg_wdata;
                CFG_MIN_RUN:      min_run_reg <= cfg_wdata[3:0];
                default:          ;
            endcase
        end
    end

    vzre_rec_fifo u_rec_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .push_rec  (recs),
        .room      (room),
        .pop_valid (m_tvalid),
        .pop_ready (m_tready),
        .pop_rec   (out_rec)
    );

    assign m_tdata = {1'b0, out_rec.run_length, out_rec.out_color,
                      out_rec.out_value, out_rec.record_kind};
    assign m_tuser = out_rec.last;
    assign m_tlast = out_rec.chunk_end;

`ifndef ASSERT_OFF
    a_chunk_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && at_end) |=> (pos_reg == '0) && (zcount_reg == '0))
        else $error("chunk boundary did not clear position and run");

    a_run_in_chunk: assert property (@(posedge clk) disable iff (!rst_n)
        zcount_reg <= RUN_W'(pos_reg))
        else $error("held run longer than chunk position");

    a_zero_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_zero && !at_end) |-> (rec_cnt == '0))
        else $error("zero voxel inside chunk released a record");

    a_rec_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rec_cnt <= REC_CNT_W'(MAX_RECS))
        else $error("voxel released too many records");
`endif

endmodule

### sv/vzre_rec_fifo.sv
// ----------------------------------------------------------------------------
// vzre_rec_fifo
// small record queue: takes up to three records in one cycle, gives one
// ----------------------------------------------------------------------------
module vzre_rec_fifo (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [vzre_pkg::REC_CNT_W-1:0]      push_cnt,
    input  vzre_pkg::rec_t                      push_rec [vzre_pkg::MAX_RECS],
    output logic                                room,
    output logic                                pop_valid,
    input  logic                                pop_ready,
    output vzre_pkg::rec_t                      pop_rec
);
    import vzre_pkg::*;

    rec_t                  entries_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] head_reg;
    logic [FIFO_PTR_W-1:0] head_next;
    logic [FIFO_PTR_W-1:0] tail_reg;
    logic [FIFO_PTR_W-1:0] tail_next;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;
    logic [FIFO_PTR_W-1:0] wr_ptr [MAX_RECS];
    logic                  pop;

    assign pop       = pop_valid && pop_ready;
    assign pop_valid = (count_reg != '0);
    assign pop_rec   = entries_reg[head_reg];
    // room for a full burst of records from one voxel
    assign room      = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - MAX_RECS));

    always_comb
    begin
        for (int i = 0; i < MAX_RECS; i++)
        begin
            wr_ptr[i] = tail_reg + FIFO_PTR_W'(i);
        end
        tail_next  = tail_reg + FIFO_PTR_W'(push_cnt);
        head_next  = pop ? head_reg + FIFO_PTR_W'(1) : head_reg;
        count_next = count_reg + FIFO_CNT_W'(push_cnt) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RECS; i++)
        begin
            if (REC_CNT_W'(i) < push_cnt)
            begin
                entries_reg[wr_ptr[i]] <= push_rec[i];
            end
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("record queue count beyond depth");

    a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (push_cnt != '0) |-> (FIFO_CNT_W'(push_cnt) + count_reg <= FIFO_CNT_W'(FIFO_DEPTH)))
        else $error("record queue overflow");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push_cnt == '0 && !pop) |=> $stable(count_reg) && $stable(tail_reg))
        else $error("record queue moved without push or pop");
`endif

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the voxel zero run encoder
// ----------------------------------------------------------------------------
// voxels are queued phase by phase and sent on the s_ stream in random bursts.
// a behavioral encoder predicts the records of every voxel taken. the records
// on the m_ stream are compared field by field against the oldest prediction.
// registers are changed only while nothing is in flight, and one change
// lands in the middle of a held run.
// ----------------------------------------------------------------------------
module testbench;

    import vzre_pkg::*;

    typedef enum int {
        RX_FREE,
        RX_COIN,
        RX_SLOW,
        RX_PERIODIC
    } rx_mode_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic [15:0]          s_tdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [31:0]          m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_wdata = '0;

    // voxels waiting to be sent, {color, value}
    logic [15:0] voxel_backlog [$];
    // records predicted but not yet seen on the output
    rec_t        pending_records [$];
    rec_t        step_records [$];

    // predictor state and register copies
    int          chunk_pos = 0;
    int          held_zeros = 0;
    logic [7:0]  marker_reg = 8'd255;
    logic [3:0]  min_run_reg = 4'd3;

    int          burst_left = 0;
    int          gap_left = 0;
    rx_mode_t    rx_mode = RX_FREE;
    int          rx_left = 0;
    int          fail_count = 0;

    voxel_zero_run_encoder_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #6 clk = ~clk;

    function automatic void add_record(input rec_kind_t kind, input logic [7:0] val,
                                       input logic [7:0] col, input int len);
        rec_t r;
        r.record_kind = kind;
        r.out_value   = val;
        r.out_color   = col;
        r.run_length  = len[RUN_W-1:0];
        r.chunk_end   = 1'b0;
        r.last        = 1'b0;
        step_records.push_back(r);
    endfunction

    function automatic void release_held_zeros();
        int thr;
        thr = (min_run_reg == 4'd0) ? 1 : int'(min_run_reg);
        if (thr > int'(THRESHOLD_CAP))
            thr = int'(THRESHOLD_CAP);
        if (held_zeros >= thr && held_zeros > 0)
            add_record(KIND_RUN, marker_reg, marker_reg, held_zeros);
        else
            repeat (held_zeros) add_record(KIND_LITERAL, 8'd0, 8'd0, 0);
        held_zeros = 0;
    endfunction

    function automatic void encode_voxel(input logic [7:0] val, input logic [7:0] col);
        logic at_end;
        rec_t r;
        at_end = (chunk_pos == CHUNK_VOXELS - 1);
        step_records.delete();
        if (val == 8'd0) begin
            if (held_zeros < 8191)
                held_zeros++;
            if (at_end) begin
                if (held_zeros >= CHUNK_VOXELS) begin
                    add_record(KIND_EMPTY, 8'd0, 8'd0, 0);
                    held_zeros = 0;
                end
                else
                    release_held_zeros();
            end
        end
        else begin
            release_held_zeros();
            add_record(KIND_LITERAL, val, col, 0);
        end
        if (at_end) begin
            chunk_pos  = 0;
            held_zeros = 0;
        end
        else
            chunk_pos++;
        if (step_records.size() > 0) begin
            r = step_records.pop_back();
            r.last      = 1'b1;
            r.chunk_end = at_end;
            step_records.push_back(r);
        end
        foreach (step_records[i])
            pending_records.push_back(step_records[i]);
    endfunction

    // sender: bursts of random length with random gaps
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                encode_voxel(s_tdata[7:0], s_tdata[15:8]);
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (voxel_backlog.size() > 0)
                begin
                    s_tdata  <= voxel_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(80, 300)
                                                                 : $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern is redrawn at random
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rx_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_left = $urandom_range(10, 150);
            end
            else
                rx_left--;
            case (rx_mode)
                RX_FREE:     m_tready <= 1'b1;
                RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
                RX_SLOW:     m_tready <= ($urandom_range(0, 3) == 0);
                default:     m_tready <= ((rx_left % 8) < 5);
            endcase
        end
    end

    always @(posedge clk)
    begin
        rec_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_records.size() == 0)
            begin
                $error("record word with nothing expected: tdata %h", m_tdata);
                fail_count++;
            end
            else
            begin
                want = pending_records.pop_front();
                if (m_tdata[1:0] !== want.record_kind)
                begin
                    $error("record_kind mismatch: expected %0d, got %0d",
                           want.record_kind, m_tdata[1:0]);
                    fail_count++;
                end
                if (m_tdata[9:2] !== want.out_value)
                begin
                    $error("out_value mismatch: expected %0d, got %0d",
                           want.out_value, m_tdata[9:2]);
                    fail_count++;
                end
                if (m_tdata[17:10] !== want.out_color)
                begin
                    $error("out_color mismatch: expected %0d, got %0d",
                           want.out_color, m_tdata[17:10]);
                    fail_count++;
                end
                if (m_tdata[30:18] !== want.run_length)
                begin
                    $error("run_length mismatch: expected %0d, got %0d",
                           want.run_length, m_tdata[30:18]);
                    fail_count++;
                end
                if (m_tlast !== want.chunk_end)
                begin
                    $error("chunk_end mismatch: expected %0d, got %0d",
                           want.chunk_end, m_tlast);
                    fail_count++;
                end
                if (m_tuser !== want.last)
                begin
                    $error("last mismatch: expected %0d, got %0d", want.last, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    task automatic queue_voxel(input logic [7:0] val, input logic [7:0] col);
        voxel_backlog.push_back({col, val});
    endtask

    task automatic queue_zeros(input int n);
        repeat (n) queue_voxel(8'd0, 8'($urandom_range(0, 255)));
    endtask

    // literals, short and long zero runs, and extreme values
    task automatic queue_random(input int n);
        int left;
        int len;
        int pick;
        left = n;
        while (left > 0)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                queue_voxel(8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)));
                left--;
            end
            else if (pick < 85)
            begin
                len = (pick < 72) ? $urandom_range(1, 4) : $urandom_range(5, 30);
                if (len > left)
                    len = left;
                queue_zeros(len);
                left -= len;
            end
            else
            begin
                queue_voxel($urandom_range(0, 1) ? 8'd255 : 8'd1,
                            $urandom_range(0, 1) ? 8'd255 : 8'd0);
                left--;
            end
        end
    endtask

    // nothing queued and nothing in flight
    task automatic wait_idle();
        while (voxel_backlog.size() != 0 || s_tvalid || pending_records.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_MARKER_VALUE)
            marker_reg = data;
        else if (idx == CFG_MIN_RUN)
            min_run_reg = data[3:0];
        @(negedge clk);
    endtask

    initial
    begin
        logic [3:0] run_settings [6];
        logic [7:0] marker_settings [6];
        run_settings    = '{4'd2, 4'd4, 4'd1, 4'd0, 4'd3, 4'd15};
        marker_settings = '{8'd0, 8'd255, 8'h80, 8'h7f, 8'h5a, 8'h01};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset registers: literals, a lone zero, two zeros, a run at the threshold
        queue_voxel(8'd255, 8'd255);
        queue_voxel(8'd1, 8'd0);
        queue_voxel(8'd0, 8'hff);
        queue_voxel(8'h2a, 8'h01);
        queue_zeros(2);
        queue_voxel(8'h55, 8'haa);
        queue_zeros(3);
        queue_voxel(8'h01, 8'hff);
        queue_zeros(6);
        queue_voxel(8'hfe, 8'h80);
        wait_idle();

        // zero threshold acts as one, marker of zero
        write_reg(CFG_MIN_RUN, 8'd0);
        write_reg(CFG_MARKER_VALUE, 8'd0);
        queue_zeros(1);
        queue_voxel(8'h33, 8'h44);
        wait_idle();

        // oversized threshold saturates
        write_reg(CFG_MIN_RUN, 8'd15);
        queue_zeros(3);
        queue_voxel(8'h80, 8'h7f);

        // registers change while two zeros are held back
        queue_zeros(2);
        wait_idle();
        write_reg(CFG_MIN_RUN, 8'd1);
        write_reg(CFG_MARKER_VALUE, 8'ha5);
        queue_voxel(8'h10, 8'h20);
        wait_idle();

        foreach (run_settings[i])
        begin
            write_reg(CFG_MIN_RUN, {4'd0, run_settings[i]});
            write_reg(CFG_MARKER_VALUE,
                      ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255))
                                                  : marker_settings[i]);
            queue_random(60);
            wait_idle();
        end

        write_reg(CFG_MIN_RUN, 8'd2);
        queue_random(40);
        wait_idle();
        repeat (20) @(posedge clk);

        if (fail_count == 0)
            $display("[voxel_zero_run_encoder_top] OK");
        else
            $display("[voxel_zero_run_encoder_top] ERROR");
        $finish;
    end

    initial
    begin
        #30_000_000;
        $display("[voxel_zero_run_encoder_top] ERROR");
        $finish;
    end

endmodule
